@@ hw/rtl/demand_page_table_translate_macros.svh @@
// Assertion macros for the page table translator.
`ifndef DEMAND_PAGE_TABLE_TRANSLATE_MACROS_SVH
`define DEMAND_PAGE_TABLE_TRANSLATE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define DPTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dptt assertion failed");
// Next-cycle implication.
`define DPTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dptt assertion failed");
`else
`define DPTT_ASSERT_NOW(label, clk, rst, ante, cons)
`define DPTT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/dptt_pkg.sv @@
package dptt_pkg;

  localparam int OFFSET_BITS_W    = 4;
  localparam int FRAME_COUNT_W    = 7;
  localparam int PAGE_NUMBER_W    = 16;
  localparam int FRAME_NUMBER_W   = 6;
  localparam int PHYS_ADDR_W      = 21;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 4'd8;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 7'd64;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_OFFSET_BITS = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MAPPED  = 2'd1,
    ST_NOFRAME = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'b01,
    MODE_RUN   = 2'b10
  } mode_t;

endpackage

@@ hw/rtl/demand_page_table_translate.sv @@
// Demand-paged single-level page table translator.
//
// Input channel: one virtual_address word per handshake (in_valid/in_ready).
// Output channel: page_number, frame_number, physical_address and status per
// word (out_valid/out_ready). Every input word yields exactly one output word.
// Config: APB-style port, offset_bits at 0x0, frame_count at 0x4, pready tied
// high; write only while the block is idle.
//
// An accepted word goes through the lookup stage, then the output register.
// Throughput: one word per cycle while out_ready is high, set by the page
// table RAM (one read port, one write port, registered read). A mapping
// written by one word is forwarded to the very next word if on the same page.
// Frames are handed out in order and never freed, so frame use is a single
// allocation pointer rather than a bitmap.
//
// Reset: config returns to offset_bits=8, frame_count=64, and a clearing pass
// zeroes every page table entry; in_ready stays low meanwhile.
// A stalled receiver holds the output register; one more word can then sit
// in the lookup stage before in_ready drops.
module demand_page_table_translate #(
  parameter int MAX_PAGES  = 256,
  parameter int MAX_FRAMES = 64,
  parameter int ADDR_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ADDR_BITS-1:0]                virtual_address,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dptt_pkg::PAGE_NUMBER_W-1:0]  page_number,
  output logic [dptt_pkg::FRAME_NUMBER_W-1:0] frame_number,
  output logic [dptt_pkg::PHYS_ADDR_W-1:0]    physical_address,
  output logic [1:0]                          status,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dptt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dptt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dptt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import dptt_pkg::*;

`include "demand_page_table_translate_macros.svh"

  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W   = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;
  localparam int CMP_W   = ((ADDR_BITS > PAGE_W) ? ADDR_BITS : PAGE_W) + 1;
  localparam int PN_W    = (ADDR_BITS > PAGE_NUMBER_W) ? ADDR_BITS : PAGE_NUMBER_W;
  localparam int FN_W    = (FRAME_W > FRAME_NUMBER_W) ? FRAME_W : FRAME_NUMBER_W;
  localparam int SH_W    = FRAME_W + (1 << OFFSET_BITS_W) - 1;
  localparam int WIDE_W0 = (SH_W > PHYS_ADDR_W) ? SH_W : PHYS_ADDR_W;
  localparam int WIDE_W  = (WIDE_W0 > ADDR_BITS) ? WIDE_W0 : ADDR_BITS;
  localparam int ENTRY_W = FRAME_W + 1;

  // ---------------- configuration ----------------
  logic [OFFSET_BITS_W-1:0] offset_bits;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_OFFSET_BITS: prdata = CFG_DATA_W'(offset_bits);
      REG_FRAME_COUNT: prdata = CFG_DATA_W'(frame_count);
      default:         prdata = '0;
    endcase
  end

  // ---------------- control state ----------------
  mode_t             mode;
  logic [PAGE_W-1:0] clr_idx;
  logic              b_valid;
  logic [CNT_W-1:0]  alloc_ptr;     // frames [0, alloc_ptr) are in use
  logic              fwd_hit;       // lookup word's page was written on its read edge

  // ---------------- lookup stage payload ----------------
  logic [ADDR_BITS-1:0] b_page;
  logic [ADDR_BITS-1:0] b_offs;
  logic                 b_beyond;
  logic [FRAME_W-1:0]   fwd_frame;

  // ---------------- input decode ----------------
  logic                 in_fire;
  logic [ADDR_BITS-1:0] in_page;
  logic [ADDR_BITS-1:0] in_offs;
  logic [CMP_W-1:0]     in_page_ext;
  logic [PAGE_W-1:0]    in_idx;
  logic                 in_beyond;

  assign in_page     = virtual_address >> offset_bits;
  assign in_offs     = virtual_address & ~({ADDR_BITS{1'b1}} << offset_bits);
  assign in_page_ext = CMP_W'(in_page);
  assign in_idx      = in_page_ext[PAGE_W-1:0];
  assign in_beyond   = in_page_ext >= CMP_W'(MAX_PAGES);

  // ---------------- page table RAM ----------------
  logic               ram_we;
  logic [PAGE_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  dptt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_PAGES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  // ---------------- lookup stage logic ----------------
  logic [CMP_W-1:0]   b_page_ext;
  logic [PAGE_W-1:0]  b_idx;
  logic               b_present;
  logic [FRAME_W-1:0] b_frame;
  logic               frame_free;
  logic [FRAME_W-1:0] alloc_frame;
  status_t            b_status;
  logic [FRAME_W-1:0] res_frame;
  logic               b_adv;
  logic               map_we;

  assign b_page_ext  = CMP_W'(b_page);
  assign b_idx       = b_page_ext[PAGE_W-1:0];
  assign b_present   = fwd_hit || ram_rdata[FRAME_W];
  assign b_frame     = fwd_hit ? fwd_frame : ram_rdata[FRAME_W-1:0];
  assign alloc_frame = alloc_ptr[FRAME_W-1:0];
  // frame_count above MAX_FRAMES saturates through the second compare
  assign frame_free  = (LIM_W'(alloc_ptr) < LIM_W'(frame_count)) &&
                       (alloc_ptr < CNT_W'(MAX_FRAMES));

  always_comb begin
    priority if (b_beyond) begin
      b_status  = ST_BEYOND;
      res_frame = '0;
    end else if (b_present) begin
      b_status  = ST_HIT;
      res_frame = b_frame;
    end else if (frame_free) begin
      b_status  = ST_MAPPED;
      res_frame = alloc_frame;
    end else begin
      b_status  = ST_NOFRAME;
      res_frame = '0;
    end
  end

  assign b_adv    = b_valid && (!out_valid || out_ready);
  assign in_ready = (mode == MODE_RUN) && (!b_valid || b_adv);
  assign in_fire  = in_valid && in_ready;
  assign map_we   = b_adv && (b_status == ST_MAPPED);

  assign ram_we    = (mode == MODE_CLEAR) || map_we;
  assign ram_waddr = (mode == MODE_CLEAR) ? clr_idx : b_idx;
  assign ram_wdata = (mode == MODE_CLEAR) ? '0 : {1'b1, alloc_frame};

  // result formatting
  logic [WIDE_W-1:0] phys_wide;
  logic [PN_W-1:0]   page_wide;
  logic [FN_W-1:0]   frame_wide;

  assign phys_wide  = (b_status == ST_HIT || b_status == ST_MAPPED) ?
                      ((WIDE_W'(res_frame) << offset_bits) | WIDE_W'(b_offs)) : '0;
  assign page_wide  = PN_W'(b_page);
  assign frame_wide = FN_W'(res_frame);

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      frame_count <= FRAME_COUNT_RST;
      mode        <= MODE_CLEAR;
      clr_idx     <= '0;
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
      alloc_ptr   <= '0;
      fwd_hit     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_OFFSET_BITS: offset_bits <= pwdata[OFFSET_BITS_W-1:0];
          REG_FRAME_COUNT: frame_count <= pwdata[FRAME_COUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (mode)
        MODE_CLEAR: begin
          clr_idx <= clr_idx + PAGE_W'(1);
          if (clr_idx == PAGE_W'(MAX_PAGES - 1)) begin
            mode <= MODE_RUN;
          end
        end
        MODE_RUN: ;
        default: mode <= MODE_CLEAR;
      endcase
      if (in_fire) begin
        b_valid <= 1'b1;
        // the RAM read on this edge misses a write to the same page
        fwd_hit <= map_we && (b_idx == in_idx);
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (map_we) begin
        alloc_ptr <= alloc_ptr + CNT_W'(1);
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_page    <= in_page;
      b_offs    <= in_offs;
      b_beyond  <= in_beyond;
      fwd_frame <= alloc_frame;
    end
    if (b_adv) begin
      page_number      <= page_wide[PAGE_NUMBER_W-1:0];
      frame_number     <= frame_wide[FRAME_NUMBER_W-1:0];
      physical_address <= phys_wide[PHYS_ADDR_W-1:0];
      status           <= b_status;
    end
  end

  // ---------------- assertions ----------------
  `DPTT_ASSERT_NOW(a_clear_blocks_input, clk, rst, mode == MODE_CLEAR, !in_ready && !b_valid)
  `DPTT_ASSERT_NEXT(a_map_bumps_ptr, clk, rst, map_we, alloc_ptr == $past(alloc_ptr) + CNT_W'(1))
  `DPTT_ASSERT_NEXT(a_fwd_capture, clk, rst, in_fire && map_we && (b_idx == in_idx), fwd_hit)

endmodule

@@ hw/rtl/dptt_ram.sv @@
module dptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns old data on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ verif/tb_demand_page_table_translate.sv @@
module tb_demand_page_table_translate;
  import dptt_pkg::*;

  localparam int MAX_PAGES  = 256;
  localparam int MAX_FRAMES = 64;
  localparam int ADDR_BITS  = 16;
  // Slowest legal run is roughly 1700 words with random gaps and stalls plus
  // the clearing pass; this leaves several times that as margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 138;

  // One translation result as seen on the output channel.
  typedef struct {
    logic [PAGE_NUMBER_W-1:0]  page;
    logic [FRAME_NUMBER_W-1:0] frame;
    logic [PHYS_ADDR_W-1:0]    phys;
    status_t                   st;
  } xlation_t;

  // Shadow page table plus queue of translations still owed by the block.
  class xlate_tracker;
    logic [OFFSET_BITS_W-1:0]  ob;
    logic [FRAME_COUNT_W-1:0]  fc;
    bit                        present [MAX_PAGES];
    logic [FRAME_NUMBER_W-1:0] frame_of [MAX_PAGES];
    bit                        used [MAX_FRAMES];
    xlation_t                  owed_q[$];
    int                        errors;

    function new();
      ob = OFFSET_BITS_RST;
      fc = FRAME_COUNT_RST;
      errors = 0;
      foreach (present[i]) present[i] = 1'b0;
      foreach (frame_of[i]) frame_of[i] = '0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_OFFSET_BITS) ob = v[OFFSET_BITS_W-1:0];
      else fc = v[FRAME_COUNT_W-1:0];
    endfunction

    // Translate one accepted address and update the shadow table.
    function void note_address(logic [ADDR_BITS-1:0] va);
      xlation_t     x;
      int unsigned  pg;
      int unsigned  offs;
      int unsigned  lim;
      int           fr;
      int unsigned  phys32;
      pg   = va >> ob;
      offs = va & ((32'd1 << ob) - 1);
      x.page  = pg[PAGE_NUMBER_W-1:0];
      x.frame = '0;
      x.phys  = '0;
      if (pg >= MAX_PAGES) begin
        x.st = ST_BEYOND;
      end else if (present[pg]) begin
        x.frame = frame_of[pg];
        x.st = ST_HIT;
      end else begin
        // lowest free frame below the (saturated) frame count
        lim = (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
        fr = -1;
        for (int f = 0; f < lim; f++) begin
          if (!used[f] && fr < 0) fr = f;
        end
        if (fr < 0) begin
          x.st = ST_NOFRAME;
        end else begin
          present[pg]  = 1'b1;
          frame_of[pg] = fr[FRAME_NUMBER_W-1:0];
          used[fr]     = 1'b1;
          x.frame = fr[FRAME_NUMBER_W-1:0];
          x.st = ST_MAPPED;
        end
      end
      if (x.st == ST_HIT || x.st == ST_MAPPED) begin
        phys32 = (32'(x.frame) << ob) | offs;
        x.phys = phys32[PHYS_ADDR_W-1:0];
      end
      owed_q.push_back(x);
    endfunction

    function void check_result(logic [PAGE_NUMBER_W-1:0] pn, logic [FRAME_NUMBER_W-1:0] fn,
                               logic [PHYS_ADDR_W-1:0] pa, logic [1:0] st);
      xlation_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: page %h frame %h phys %h status %0d",
                 $time, pn, fn, pa, st);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (pn !== want.page) begin
        $display("%0t: page_number exp %h got %h", $time, want.page, pn);
        errors++;
      end
      if (fn !== want.frame) begin
        $display("%0t: frame_number exp %h got %h", $time, want.frame, fn);
        errors++;
      end
      if (pa !== want.phys) begin
        $display("%0t: physical_address exp %h got %h", $time, want.phys, pa);
        errors++;
      end
      if (st !== 2'(want.st)) begin
        $display("%0t: status exp %0d got %0d", $time, want.st, st);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ADDR_BITS-1:0]       virtual_address = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [PAGE_NUMBER_W-1:0]   page_number;
  logic [FRAME_NUMBER_W-1:0]  frame_number;
  logic [PHYS_ADDR_W-1:0]     physical_address;
  logic [1:0]                 status;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  xlate_tracker tracker = new();
  bit           calm = 1'b0;   // phase with no idling on either side
  int           cycles = 0;

  always #1 clk = ~clk;

  demand_page_table_translate #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_FRAMES(MAX_FRAMES),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .virtual_address (virtual_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .page_number     (page_number),
    .frame_number    (frame_number),
    .physical_address(physical_address),
    .status          (status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // ---------------------------------------------------------------------
  // Monitors: sample handshakes with pre-edge values. Input side first so a
  // word accepted in the same cycle as a result is queued behind it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_address(virtual_address);
      if (out_valid && out_ready)
        tracker.check_result(page_number, frame_number, physical_address, status);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall before each result word, none in calm phases.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks (called at a rising edge)
  // ---------------------------------------------------------------------

  // Send one address word; valid stays up across back-to-back words.
  task automatic send_address(input logic [ADDR_BITS-1:0] va);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    virtual_address <= va;
    do @(posedge clk); while (!in_ready);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, v);
  endtask

  // Drop valid and wait for every owed result before touching config.
  // Waiting starts after the monitor has queued the last accepted word.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input int ob, input int fc);
    drain();
    cfg_write(REG_OFFSET_BITS, CFG_DATA_W'(ob));
    cfg_write(REG_FRAME_COUNT, CFG_DATA_W'(fc));
  endtask

  // Random address shaped to land mostly inside the table: a mix of a few
  // hot low pages (hits), any table page (fresh maps / faults) and raw noise.
  function automatic logic [ADDR_BITS-1:0] pick_address();
    int unsigned ob;
    int unsigned top_pg;
    int unsigned pg;
    int unsigned pick;
    int unsigned a;
    ob     = tracker.ob;
    top_pg = 32'hFFFF >> ob;
    if (top_pg > MAX_PAGES - 1) top_pg = MAX_PAGES - 1;
    pick = $urandom_range(0, 99);
    if (pick < 15) return ADDR_BITS'($urandom);
    if (pick < 50) pg = $urandom_range(0, (top_pg < 15) ? top_pg : 15);
    else pg = $urandom_range(0, top_pg);
    a = (pg << ob) | ($urandom & ((32'd1 << ob) - 1));
    return a[ADDR_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int ob_plan [12];
    int fc_plan [12];
    ob_plan = '{8, 0, 15, 4, 12, 9, 1, 8, 6, 10, 3, 7};
    fc_plan = '{3, 0, 8, 16, 127, 24, 32, 40, 64, 100, 50, 64};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config (offset 8, 64 frames): first maps, max offset hit,
    // same page back to back to exercise the write-to-read forwarding.
    calm = 1'b1;
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'h1234);
    send_address(16'h1200);
    send_address(16'h12FF);
    send_address(16'hFFFF);
    send_address(16'hAAAA);
    send_address(16'h5555);
    calm = 1'b0;

    // No offset and no frames: table pages hit or fault, the rest are
    // beyond the table.
    set_mode(0, 0);
    send_address(16'h00FF);
    send_address(16'h0080);
    send_address(16'h0100);
    send_address(16'hFFFF);

    // Widest offset, out-of-range frame count saturates to MAX_FRAMES.
    set_mode(15, 127);
    send_address(16'h8000);
    send_address(16'h7FFF);
    send_address(16'hFFFF);

    // Frame count lowered below frames already handed out: old mappings
    // still hit, new misses fault.
    set_mode(4, 2);
    send_address(16'h0050);
    send_address(16'h0003);
    send_address(16'h0FF0);
    send_address(16'h0FFF);
    set_mode(8, 64);
    send_address(16'h0000);

    // Random phases: frame count mostly climbs so mapping keeps going.
    for (int ph = 0; ph < 12; ph++) begin
      set_mode(ob_plan[ph], fc_plan[ph]);
      calm = (ph % 4 == 2);
      for (int n = 0; n < PHASE_WORDS; n++) send_address(pick_address());
      calm = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dptt_pkg.sv
hw/rtl/dptt_ram.sv
hw/rtl/demand_page_table_translate.sv
verif/tb_demand_page_table_translate.sv
